[src/ect_pkg.sv]
// Shared types and constants for the expiring credit table.
// No dependencies.
package ect_pkg;

  localparam int unsigned TW = 63;   // time, credit and total width
  localparam int unsigned GW = 24;   // gain / modifier width (Q8.16)
  localparam int unsigned KW = 4;    // bonus type width

  localparam logic [TW-1:0] SAT_MAX = {TW{1'b1}};

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_ADD    = 2'd1,
    REQ_QUERY  = 2'd2,
    REQ_EXPIRE = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    CFG_ENABLED = 2'd0,
    CFG_KIND    = 2'd1,
    CFG_CAP     = 2'd2,
    CFG_GAIN    = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [TW-1:0] expiry;
    logic [TW-1:0] credit;
  } bucket_t;

  function automatic logic [TW-1:0] sat_add(input logic [TW-1:0] a, input logic [TW-1:0] b);
    logic [TW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TW] ? SAT_MAX : s[TW-1:0];
  endfunction

endpackage

[src/ect_scale.sv]
// Bit-serial scaled gain: q = floor(c * g / cap), c <= cap, cap > 0.
// Depends on ect_pkg.
module ect_scale (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [ect_pkg::TW-1:0]    c_in,
  input  logic [ect_pkg::GW-1:0]    g_in,
  input  logic [ect_pkg::TW-1:0]    cap_in,
  output logic                      done,
  output logic [ect_pkg::GW-1:0]    q
);

  localparam int unsigned BW = $clog2(ect_pkg::GW);

  logic                     busy_r, busy_nxt;
  logic                     phase_r, phase_nxt;   // 0: shift step, 1: add step
  logic                     done_r, done_nxt;
  logic [BW-1:0]            bit_r, bit_nxt;
  logic [ect_pkg::TW:0]     rem_r, rem_nxt;
  logic [ect_pkg::GW-1:0]   q_r, q_nxt;
  logic [ect_pkg::TW-1:0]   c_r, cap_r;
  logic [ect_pkg::GW-1:0]   g_r;
  logic [ect_pkg::TW:0]     trial;
  logic                     take;

  always_comb begin
    busy_nxt  = busy_r;
    phase_nxt = phase_r;
    done_nxt  = 1'b0;
    bit_nxt   = bit_r;
    rem_nxt   = rem_r;
    q_nxt     = q_r;
    trial     = '0;
    take      = 1'b0;
    if (start) begin
      busy_nxt  = 1'b1;
      phase_nxt = 1'b0;
      bit_nxt   = BW'(ect_pkg::GW - 1);
      rem_nxt   = '0;
      q_nxt     = '0;
    end else if (busy_r) begin
      if (!phase_r) begin
        trial = {rem_r[ect_pkg::TW-1:0], 1'b0};
        take  = 1'b1;
        q_nxt = {q_r[ect_pkg::GW-2:0], 1'b0};
      end else begin
        trial = rem_r + {1'b0, c_r};
        take  = g_r[bit_r];
      end
      if (take) begin
        if (trial >= {1'b0, cap_r}) begin
          rem_nxt = trial - {1'b0, cap_r};
          q_nxt   = q_nxt + ect_pkg::GW'(1);
        end else begin
          rem_nxt = trial;
        end
      end
      phase_nxt = ~phase_r;
      if (phase_r) begin
        if (bit_r == '0) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end else begin
          bit_nxt = bit_r - BW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      phase_r <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      phase_r <= phase_nxt;
      done_r  <= done_nxt;
    end
    bit_r <= bit_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    if (start) begin
      c_r   <= c_in;
      g_r   <= g_in;
      cap_r <= cap_in;
    end
  end

  assign done = done_r;
  assign q    = q_r;

endmodule

[src/expiring_credit_table.sv]
// Expiring credit table: top level with bucket memory and request sequencer.
// Depends on ect_pkg and ect_scale.
//
// Buckets sit in a circular buffer memory (one read, one write port, registered
// read); dropping expired buckets only moves the head pointer. One request is
// worked at a time. Clear, refused or disabled requests and a query of type zero
// go straight to the result; other requests first drop expired buckets, each
// visited bucket waiting on the registered memory read. An add then scans for
// its expiry and merges into a matching bucket, or moves later buckets up to
// open the slot and inserts; a matching query waits on the bit-serial scaler.
module expiring_credit_table #(
  parameter int unsigned BUCKETS  = 32,
  parameter int unsigned KIND_MAX = 15
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // current_time[62:0], credit_amount[125:63], expiry_time[188:126], asked_kind[192:189]
  input  logic [199:0] in_tdata,
  // req_type[1:0]
  input  logic [1:0] in_tuser,
  output logic out_tvalid,
  input  logic out_tready,
  // accepted[0], modifier_value[24:1], credit_total[87:25], entries_used[93:88],
  // earliest_expiry[156:94]
  output logic [159:0] out_tdata,
  input  logic cfg_wr_en,
  input  logic [1:0] cfg_addr,
  input  logic [62:0] cfg_wr_data
);

  localparam int unsigned TW    = ect_pkg::TW;
  localparam int unsigned GW    = ect_pkg::GW;
  localparam int unsigned KW    = ect_pkg::KW;
  localparam int unsigned CW    = $clog2(BUCKETS + 1);
  localparam int unsigned IW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned AW    = CW + 1;
  localparam int unsigned EW    = 6;   // entries_used field width
  localparam int unsigned OUT_F = 1 + GW + TW + EW + TW;
  localparam int unsigned OUT_W = ((OUT_F + 7) / 8) * 8;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_DRD  = 10'b0000000010,
    S_DCHK = 10'b0000000100,
    S_SRD  = 10'b0000001000,
    S_SCHK = 10'b0000010000,
    S_SHRD = 10'b0000100000,
    S_SHWR = 10'b0001000000,
    S_INS  = 10'b0010000000,
    S_DIV  = 10'b0100000000,
    S_FIN  = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  ect_pkg::bucket_t mem [BUCKETS];
  ect_pkg::bucket_t rd_data_r;
  logic             rd_en;
  logic [IW-1:0]    rd_addr;
  logic             wr_en;
  logic [IW-1:0]    wr_addr;
  ect_pkg::bucket_t wr_data;

  logic            en_r;
  logic [KW-1:0]   kind_r;
  logic [TW-1:0]   cap_r;
  logic [GW-1:0]   gain_r;

  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [IW-1:0]   head_r, head_nxt;
  logic [TW-1:0]   total_r, total_nxt;
  logic [TW-1:0]   hexp_r, hexp_nxt;
  logic [CW-1:0]   idx_r, idx_nxt;   // scan position, then move position
  logic [CW-1:0]   pos_r, pos_nxt;
  logic            ok_r, ok_nxt;
  logic [GW-1:0]   mod_r, mod_nxt;

  ect_pkg::req_t   req_r;
  logic [TW-1:0]   now_r, amt_r, exp_r;
  logic [KW-1:0]   ask_r;

  logic               out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]   out_data_r;

  logic               div_start;
  logic               div_done;
  logic [GW-1:0]      div_q;
  logic [TW-1:0]      div_c;
  logic               in_fire;
  logic [TW-1:0]      merged;

  function automatic logic [IW-1:0] phys(input logic [IW-1:0] hd, input logic [CW-1:0] off);
    logic [AW-1:0] s;
    s = AW'(hd) + AW'(off);
    if (s >= AW'(BUCKETS)) s = s - AW'(BUCKETS);
    return s[IW-1:0];
  endfunction

  assign in_fire   = in_tvalid && (state_r == S_IDLE);
  assign in_tready = (state_r == S_IDLE);
  assign div_c     = (total_r < cap_r) ? total_r : cap_r;
  assign merged    = ect_pkg::sat_add(rd_data_r.credit, amt_r);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    head_nxt  = head_r;
    total_nxt = total_r;
    hexp_nxt  = hexp_r;
    idx_nxt   = idx_r;
    pos_nxt   = pos_r;
    ok_nxt    = ok_r;
    mod_nxt   = mod_r;
    rd_en     = 1'b0;
    rd_addr   = phys(head_r, idx_r);
    wr_en     = 1'b0;
    wr_addr   = phys(head_r, idx_r);
    wr_data   = rd_data_r;
    div_start = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          mod_nxt = '0;
          ok_nxt  = 1'b1;
          if (!en_r) begin
            ok_nxt    = 1'b0;
            state_nxt = S_FIN;
          end else begin
            unique case (ect_pkg::req_t'(in_tuser))
              ect_pkg::REQ_CLEAR: begin
                cnt_nxt   = '0;
                total_nxt = '0;
                hexp_nxt  = '0;
                state_nxt = S_FIN;
              end
              ect_pkg::REQ_ADD: begin
                if (kind_r == '0 || in_tdata[125:63] == '0 ||
                    in_tdata[188:126] <= in_tdata[62:0]) begin
                  ok_nxt    = 1'b0;
                  state_nxt = S_FIN;
                end else begin
                  state_nxt = S_DRD;
                end
              end
              ect_pkg::REQ_QUERY: begin
                state_nxt = (in_tdata[192:189] == '0) ? S_FIN : S_DRD;
              end
              ect_pkg::REQ_EXPIRE: state_nxt = S_DRD;
              default: state_nxt = S_FIN;
            endcase
          end
        end
      end

      S_DRD: begin
        if (cnt_r == '0) begin
          hexp_nxt = '0;
        end else begin
          rd_en   = 1'b1;
          rd_addr = head_r;
        end
      end

      S_DCHK: begin
        if (rd_data_r.expiry <= now_r) begin
          total_nxt = (total_r >= rd_data_r.credit) ? total_r - rd_data_r.credit : '0;
          head_nxt  = phys(head_r, CW'(1));
          cnt_nxt   = cnt_r - CW'(1);
          state_nxt = S_DRD;
        end else begin
          hexp_nxt = rd_data_r.expiry;
        end
      end

      S_SRD: begin
        if (idx_r == cnt_r) begin
          pos_nxt = idx_r;
          if (cnt_r >= CW'(BUCKETS)) begin
            ok_nxt    = 1'b0;
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_INS;
          end
        end else begin
          rd_en     = 1'b1;
          state_nxt = S_SCHK;
        end
      end

      S_SCHK: begin
        if (rd_data_r.expiry < exp_r) begin
          idx_nxt   = idx_r + CW'(1);
          state_nxt = S_SRD;
        end else if (rd_data_r.expiry == exp_r) begin
          wr_en          = 1'b1;
          wr_data.credit = merged;
          total_nxt      = ect_pkg::sat_add(total_r, merged - rd_data_r.credit);
          state_nxt      = S_FIN;
        end else begin
          pos_nxt = idx_r;
          if (cnt_r >= CW'(BUCKETS)) begin
            ok_nxt    = 1'b0;
            state_nxt = S_FIN;
          end else begin
            idx_nxt   = cnt_r;
            state_nxt = S_SHRD;
          end
        end
      end

      // move entries one place up, from the tail down to the insert position
      S_SHRD: begin
        rd_en     = 1'b1;
        rd_addr   = phys(head_r, idx_r - CW'(1));
        state_nxt = S_SHWR;
      end

      S_SHWR: begin
        wr_en     = 1'b1;
        idx_nxt   = idx_r - CW'(1);
        state_nxt = (idx_r - CW'(1) == pos_r) ? S_INS : S_SHRD;
      end

      S_INS: begin
        wr_en          = 1'b1;
        wr_addr        = phys(head_r, pos_r);
        wr_data.expiry = exp_r;
        wr_data.credit = amt_r;
        cnt_nxt        = cnt_r + CW'(1);
        total_nxt      = ect_pkg::sat_add(total_r, amt_r);
        if (pos_r == '0) hexp_nxt = exp_r;
        state_nxt      = S_FIN;
      end

      S_DIV: begin
        if (div_done) begin
          mod_nxt   = div_q;
          state_nxt = S_FIN;
        end
      end

      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // leaving the drop loop: dispatch on the request
    if ((state_r == S_DRD && cnt_r == '0) ||
        (state_r == S_DCHK && rd_data_r.expiry > now_r)) begin
      unique case (req_r)
        ect_pkg::REQ_ADD: begin
          idx_nxt   = '0;
          state_nxt = S_SRD;
        end
        ect_pkg::REQ_QUERY: begin
          if (ask_r != kind_r || total_r == '0 || cap_r == '0 || gain_r == '0) begin
            state_nxt = S_FIN;
          end else begin
            div_start = 1'b1;
            state_nxt = S_DIV;
          end
        end
        default: state_nxt = S_FIN;
      endcase
    end else if (state_r == S_DRD) begin
      state_nxt = S_DCHK;
    end

    if (cfg_wr_en && cfg_addr == ect_pkg::CFG_ENABLED && !cfg_wr_data[0]) begin
      cnt_nxt   = '0;
      total_nxt = '0;
      hexp_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= mem[rd_addr];
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      head_r      <= '0;
      total_r     <= '0;
      hexp_r      <= '0;
      out_valid_r <= 1'b0;
      en_r        <= 1'b0;
      kind_r      <= '0;
      cap_r       <= TW'(1);
      gain_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      head_r      <= head_nxt;
      total_r     <= total_nxt;
      hexp_r      <= hexp_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        unique case (ect_pkg::cfg_idx_t'(cfg_addr))
          ect_pkg::CFG_ENABLED: en_r <= cfg_wr_data[0];
          ect_pkg::CFG_KIND: begin
            if ({4'b0, cfg_wr_data[KW-1:0]} <= 8'(KIND_MAX)) kind_r <= cfg_wr_data[KW-1:0];
          end
          ect_pkg::CFG_CAP:  cap_r  <= cfg_wr_data;
          ect_pkg::CFG_GAIN: gain_r <= cfg_wr_data[GW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    pos_r <= pos_nxt;
    ok_r  <= ok_nxt;
    mod_r <= mod_nxt;
    if (in_fire) begin
      req_r <= ect_pkg::req_t'(in_tuser);
      now_r <= in_tdata[62:0];
      amt_r <= in_tdata[125:63];
      exp_r <= in_tdata[188:126];
      ask_r <= in_tdata[192:189];
    end
    if (state_r == S_FIN && (!out_valid_r || out_tready)) begin
      out_data_r <= OUT_W'({hexp_r, EW'(cnt_r), total_r, mod_r, ok_r});
    end
  end

  ect_scale u_scale (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .c_in   (div_c),
    .g_in   (gain_r),
    .cap_in (cap_r),
    .done   (div_done),
    .q      (div_q)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[tb/sv/expiring_credit_table_tb.sv]
// Self-checking testbench for expiring_credit_table: drives request items and
// register writes, predicts every result in a scoreboard class. Depends on ect_pkg.
module expiring_credit_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBKT = 32;
  localparam logic [62:0] T_MAX = {63{1'b1}};

  typedef struct packed {
    logic        accepted;
    logic [23:0] modifier;
    logic [62:0] total;
    logic [5:0]  entries;
    logic [62:0] earliest;
  } credit_result_t;

  class credit_scoreboard;
    logic [62:0] bkt_expiry[NBKT];
    logic [62:0] bkt_credit[NBKT];
    int unsigned n_bkt;
    logic [62:0] total, head;
    logic        en;
    logic [3:0]  kind;
    logic [62:0] cap;
    logic [23:0] gain;
    credit_result_t awaiting[$];
    int errors, n_checked, n_added, n_full_refused, n_mod_nonzero, peak_bkt;

    function new();
      n_bkt = 0; total = '0; head = '0;
      en = 0; kind = '0; cap = 63'd1; gain = '0;
      errors = 0; n_checked = 0; n_added = 0;
      n_full_refused = 0; n_mod_nonzero = 0; peak_bkt = 0;
    endfunction

    function logic [62:0] sat_sum(logic [62:0] a, logic [62:0] b);
      logic [63:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[63] ? T_MAX : s[62:0];
    endfunction

    function void clear_all();
      n_bkt = 0; total = '0; head = '0;
    endfunction

    function void write_reg(ect_pkg::cfg_idx_t idx, logic [62:0] v);
      case (idx)
        ect_pkg::CFG_ENABLED: begin
          en = v[0];
          if (!en) clear_all();
        end
        ect_pkg::CFG_KIND: kind = v[3:0];
        ect_pkg::CFG_CAP:  cap = v;
        ect_pkg::CFG_GAIN: gain = v[23:0];
      endcase
    endfunction

    function void drop_expired(logic [62:0] now);
      int unsigned gone;
      gone = 0;
      while (gone < n_bkt && bkt_expiry[gone] <= now) begin
        total = (total >= bkt_credit[gone]) ? total - bkt_credit[gone] : '0;
        gone++;
      end
      if (gone > 0) begin
        n_bkt -= gone;
        for (int i = 0; i < n_bkt; i++) begin
          bkt_expiry[i] = bkt_expiry[i+gone];
          bkt_credit[i] = bkt_credit[i+gone];
        end
      end
      head = (n_bkt > 0) ? bkt_expiry[0] : '0;
    endfunction

    function bit add_credit(logic [62:0] now, logic [62:0] amt, logic [62:0] expy);
      int unsigned pos;
      logic [62:0] old;
      pos = 0;
      if (kind == 0 || amt == 0 || expy <= now) return 0;
      drop_expired(now);
      while (pos < n_bkt && bkt_expiry[pos] < expy) pos++;
      if (pos < n_bkt && bkt_expiry[pos] == expy) begin
        old = bkt_credit[pos];
        bkt_credit[pos] = sat_sum(old, amt);
        total = sat_sum(total, bkt_credit[pos] - old);
        return 1;
      end
      if (n_bkt >= NBKT) begin
        n_full_refused++;
        return 0;
      end
      for (int i = n_bkt; i > pos; i--) begin
        bkt_expiry[i] = bkt_expiry[i-1];
        bkt_credit[i] = bkt_credit[i-1];
      end
      bkt_expiry[pos] = expy;
      bkt_credit[pos] = amt;
      n_bkt++;
      total = sat_sum(total, amt);
      head = bkt_expiry[0];
      return 1;
    endfunction

    function logic [23:0] modifier_for(logic [62:0] now, logic [3:0] asked);
      logic [62:0]  c;
      logic [127:0] prod;
      if (asked == 0) return '0;
      drop_expired(now);
      if (asked != kind || total == 0 || cap == 0 || gain == 0) return '0;
      c = (total < cap) ? total : cap;
      prod = {65'd0, c} * {104'd0, gain};
      prod = prod / {65'd0, cap};
      return prod[23:0];
    endfunction

    function void note_request(ect_pkg::req_t r, logic [62:0] now, logic [62:0] amt,
                               logic [62:0] expy, logic [3:0] asked);
      credit_result_t e;
      e.accepted = 0;
      e.modifier = '0;
      if (en) begin
        e.accepted = 1;
        case (r)
          ect_pkg::REQ_CLEAR: begin
            drop_expired(now);
            clear_all();
          end
          ect_pkg::REQ_ADD: begin
            e.accepted = add_credit(now, amt, expy);
            if (e.accepted) n_added++;
          end
          ect_pkg::REQ_QUERY: e.modifier = modifier_for(now, asked);
          default: drop_expired(now);
        endcase
      end
      if (e.modifier != 0) n_mod_nonzero++;
      if (n_bkt > peak_bkt) peak_bkt = n_bkt;
      e.total = total;
      e.entries = n_bkt[5:0];
      e.earliest = head;
      awaiting.push_back(e);
    endfunction

    function void check_result(logic [159:0] d);
      credit_result_t e;
      n_checked++;
      if (awaiting.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
        return;
      end
      e = awaiting.pop_front();
      if (d[0] !== e.accepted) begin
        $error("accepted: expected %0d, got %0d", e.accepted, d[0]); errors++;
      end
      if (d[24:1] !== e.modifier) begin
        $error("modifier_value: expected %0h, got %0h", e.modifier, d[24:1]); errors++;
      end
      if (d[87:25] !== e.total) begin
        $error("credit_total: expected %0d, got %0d", e.total, d[87:25]); errors++;
      end
      if (d[93:88] !== e.entries) begin
        $error("entries_used: expected %0d, got %0d", e.entries, d[93:88]); errors++;
      end
      if (d[156:94] !== e.earliest) begin
        $error("earliest_expiry: expected %0d, got %0d", e.earliest, d[156:94]); errors++;
      end
    endfunction
  endclass

  logic         clk, rst_n;
  logic         in_tvalid, in_tready;
  logic [199:0] in_tdata;
  logic [1:0]   in_tuser;
  logic         out_tvalid, out_tready;
  logic [159:0] out_tdata;
  logic         cfg_wr_en;
  logic [1:0]   cfg_addr;
  logic [62:0]  cfg_wr_data;

  expiring_credit_table i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wr_data(cfg_wr_data)
  );

  credit_scoreboard sb = new();
  int unsigned n_sent = 0;
  int          hold_req = 0;
  bit          eager = 0;
  logic [62:0] tnow;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // accepted items feed the predictor; results are checked as they leave
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      sb.note_request(ect_pkg::req_t'(in_tuser), in_tdata[62:0], in_tdata[125:63],
                      in_tdata[188:126], in_tdata[192:189]);
      n_sent++;
    end
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // receiver back-pressure
  int hold_cnt = 0, rx_gap = 0;
  always @(negedge clk) begin
    int r;
    if (hold_req > 0) begin
      hold_cnt = hold_req;
      hold_req = 0;
    end
    r = $urandom_range(0, 99);
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_tready <= 0;
    end else if (eager) begin
      out_tready <= 1;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_tready <= 0;
    end else if (r < 70) begin
      out_tready <= 1;
    end else begin
      out_tready <= 0;
      rx_gap = (r < 97) ? $urandom_range(0, 3) : $urandom_range(10, 60);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (eager || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(20, 80);
  endfunction

  task automatic push(ect_pkg::req_t r, logic [62:0] now, logic [62:0] amt,
                      logic [62:0] expy, logic [3:0] asked);
    int gap;
    int unsigned n0;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1;
    in_tuser  <= r;
    in_tdata  <= {7'd0, asked, expy, amt, now};
    n0 = n_sent;
    while (n_sent == n0) @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (sb.awaiting.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(ect_pkg::cfg_idx_t idx, logic [62:0] v);
    cfg_wr_en   <= 1;
    cfg_addr    <= idx;
    cfg_wr_data <= v;
    sb.write_reg(idx, v);
    @(negedge clk);
    cfg_wr_en <= 0;
    @(negedge clk);
  endtask

  function automatic logic [62:0] rand63();
    return 63'({$urandom, $urandom});
  endfunction

  // mostly well-formed adds and queries around a slowly moving clock
  task automatic random_item(bit still);
    int r;
    logic [62:0] now, amt, expy;
    logic [3:0]  asked;
    r = $urandom_range(0, 99);
    if (!still) tnow = tnow + $urandom_range(0, 3);
    now = tnow;
    if ($urandom_range(0, 99) == 0) now = rand63();
    case ($urandom_range(0, 19))
      0:       amt = 0;
      1:       amt = rand63();
      2:       amt = T_MAX;
      default: amt = $urandom_range(1, 1000);
    endcase
    case ($urandom_range(0, 19))
      0:       expy = now - $urandom_range(0, 5);
      1:       expy = rand63();
      default: expy = now + (still ? $urandom_range(1, 200) : $urandom_range(1, 40));
    endcase
    asked = ($urandom_range(0, 3) == 0) ? 4'($urandom) : sb.kind;
    if (r < 2)       push(ect_pkg::REQ_CLEAR, now, rand63(), rand63(), 4'($urandom));
    else if (r < 55) push(ect_pkg::REQ_ADD, now, amt, expy, asked);
    else if (r < 88) push(ect_pkg::REQ_QUERY, now, rand63(), rand63(), asked);
    else             push(ect_pkg::REQ_EXPIRE, now, rand63(), rand63(), asked);
  endtask

  initial begin
    #50ms;
    $display("FAIL");
    $finish;
  end

  initial begin
    logic [62:0] caps[6];
    rst_n = 0; in_tvalid = 0; in_tdata = '0; in_tuser = '0;
    out_tready = 0; cfg_wr_en = 0; cfg_addr = '0; cfg_wr_data = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // directed: refusals while disabled, then the special cases
    push(ect_pkg::REQ_ADD, 63'd10, 63'd5, 63'd20, 4'd3);
    push(ect_pkg::REQ_QUERY, 63'd10, 63'd0, 63'd0, 4'd3);
    drain();
    write_reg(ect_pkg::CFG_ENABLED, 63'd1);
    write_reg(ect_pkg::CFG_CAP, 63'd1000);
    write_reg(ect_pkg::CFG_GAIN, 63'h7FFF_FFFF_FFFF_FFFF);  // masked to 24 bits
    push(ect_pkg::REQ_ADD, 63'd10, 63'd5, 63'd20, 4'd3);    // no kind chosen
    drain();
    write_reg(ect_pkg::CFG_KIND, 63'h7FFF_FFFF_FFFF_FFF3);
    push(ect_pkg::REQ_QUERY, 63'd10, 63'd0, 63'd0, 4'd3);   // empty table
    push(ect_pkg::REQ_ADD, 63'd10, 63'd0, 63'd20, 4'd3);    // zero amount
    push(ect_pkg::REQ_ADD, 63'd10, 63'd5, 63'd10, 4'd3);    // expiry not in future
    push(ect_pkg::REQ_ADD, 63'd10, 63'd400, 63'd20, 4'd3);
    push(ect_pkg::REQ_ADD, 63'd10, 63'd300, 63'd20, 4'd3);  // merge
    push(ect_pkg::REQ_ADD, 63'd10, 63'd100, 63'd15, 4'd3);
    push(ect_pkg::REQ_QUERY, 63'd11, 63'd0, 63'd0, 4'd3);
    push(ect_pkg::REQ_QUERY, 63'd11, 63'd0, 63'd0, 4'd0);
    push(ect_pkg::REQ_QUERY, 63'd11, 63'd0, 63'd0, 4'd15);  // type mismatch
    push(ect_pkg::REQ_ADD, 63'd11, T_MAX, 63'd30, 4'd3);    // total saturates
    push(ect_pkg::REQ_ADD, 63'd11, T_MAX, 63'd30, 4'd3);    // bucket saturates
    push(ect_pkg::REQ_QUERY, 63'd12, 63'd0, 63'd0, 4'd3);
    push(ect_pkg::REQ_EXPIRE, 63'd15, 63'd0, 63'd0, 4'd0);  // drops one bucket
    push(ect_pkg::REQ_ADD, 63'd15, 63'd1, T_MAX, 4'd3);
    push(ect_pkg::REQ_EXPIRE, T_MAX - 1, 63'd0, 63'd0, 4'd0);
    push(ect_pkg::REQ_CLEAR, 63'd0, T_MAX, T_MAX, 4'hF);
    for (int i = 0; i < NBKT + 1; i++)
      push(ect_pkg::REQ_ADD, 63'd100, 63'd7, 63'd200 + 2 * i, 4'd3);  // last one finds it full
    push(ect_pkg::REQ_ADD, 63'd100, 63'd9, 63'd204, 4'd3);  // full, but merges
    push(ect_pkg::REQ_QUERY, 63'd100, 63'd0, 63'd0, 4'd3);
    push(ect_pkg::REQ_ADD, 63'd201, 63'd9, 63'd203, 4'd3);  // full until expiry frees a slot
    drain();

    caps = '{63'd1, 63'd0, T_MAX, 63'd500, 63'd100000, 63'd3000};
    for (int ph = 0; ph < 12; ph++) begin
      drain();
      write_reg(ect_pkg::CFG_CAP, caps[ph % 6]);
      write_reg(ect_pkg::CFG_GAIN,
                (ph % 4 == 0) ? 63'hFF_FFFF : (ph % 4 == 1) ? 63'd0 : 63'($urandom));
      write_reg(ect_pkg::CFG_KIND,
                (ph == 3) ? 63'd0 : (ph == 7) ? 63'd15 : 63'($urandom_range(1, 15)));
      write_reg(ect_pkg::CFG_ENABLED, (ph == 9) ? 63'd0 : 63'd1);
      if (ph == 10) write_reg(ect_pkg::CFG_ENABLED, 63'd1);  // repeated enable keeps the table
      eager = (ph == 5);
      tnow = (ph % 3 == 2) ? T_MAX - 63'd100000 : 63'($urandom_range(0, 1 << 20));
      for (int i = 0; i < 155; i++) begin
        if (ph == 4 && i == 40) begin
          @(posedge clk) hold_req = 400;  // receiver stalls, input backs up
          @(negedge clk);
        end
        if (ph == 6 && i == 80) drain();
        random_item(ph % 4 == 1);
      end
    end
    drain();
    eager = 0;
    repeat (200) @(negedge clk);

    $display("Checked %0d results: %0d adds taken, %0d refused on a full table,",
             sb.n_checked, sb.n_added, sb.n_full_refused);
    $display("%0d nonzero modifiers, up to %0d buckets held.", sb.n_mod_nonzero, sb.peak_bkt);
    if (sb.errors == 0 && sb.awaiting.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
